[rtl/wlpc_pkg.sv]
package wlpc_pkg;

  localparam int PixW = 8;
  localparam int NumDivSteps = PixW;
  localparam int RomDepth = 1 << PixW;
  localparam int KnotCount = 15;

  typedef logic [PixW-1:0] pix_t;
  typedef logic [3*PixW-1:0] rgb_t;
  typedef rgb_t [RomDepth-1:0] cmap_rom_t;

  localparam logic [1:0] RegBlack = 2'd0;
  localparam logic [1:0] RegWhite = 2'd1;
  localparam logic [1:0] RegInvert = 2'd2;
  localparam logic [1:0] RegColor = 2'd3;

  typedef struct packed {
    logic below;
    logic above;
    pix_t rem;
    pix_t quo;
  } div_t;

  localparam int KnotTab [KnotCount][4] = '{
    '{255,   0, 255, -616},
    '{179,   0, 255, -569},
    '{120,  40, 255, -528},
    '{ 60,  96, 255, -469},
    '{  0, 175, 177, -400},
    '{  0, 191, 143, -383},
    '{  0, 207,  78, -361},
    '{ 90, 255,  60, -305},
    '{191, 255,   0, -259},
    '{239, 255,   0, -240},
    '{255, 255,   0, -229},
    '{255, 175,   0, -162},
    '{255, 105,   0,  -83},
    '{255,  45,  55,  -20},
    '{255,   0,  90,    0}
  };

  // Shift-and-subtract quotient of two non-negative constants.
  function automatic int cmap_div(int num, int den);
    int q;
    int r;
    q = 0;
    r = 0;
    for (int k = 30; k >= 0; k--) begin
      r = (r << 1) | ((num >> k) & 1);
      if (r >= den) begin
        r = r - den;
        q = q | (1 << k);
      end
    end
    return q;
  endfunction

  // Piecewise-linear interpolation over the colour knots, truncating.
  function automatic cmap_rom_t build_cmap();
    cmap_rom_t rom;
    int seg;
    int first;
    int span;
    int t;
    int n;
    int d;
    int num;
    int v;
    rom = '0;
    seg = 0;
    first = KnotTab[0][3];
    span = KnotTab[KnotCount-1][3] - first;
    for (int i = 0; i < RomDepth; i++) begin
      t = i * span + first * 255;
      if (t > 255 * KnotTab[seg+1][3]) begin
        seg = seg + 1;
        if (seg > KnotCount - 2) begin
          seg = KnotCount - 2;
        end
      end
      n = t - 255 * KnotTab[seg][3];
      d = 255 * (KnotTab[seg+1][3] - KnotTab[seg][3]);
      for (int c = 0; c < 3; c++) begin
        num = KnotTab[seg][c] * (d - n) + KnotTab[seg+1][c] * n;
        if (num <= 0) begin
          v = 0;
        end else begin
          v = cmap_div(num, d);
        end
        if (v > 255) begin
          v = 255;
        end
        rom[i][PixW*(2-c) +: PixW] = v[PixW-1:0];
      end
    end
    return rom;
  endfunction

  localparam cmap_rom_t CmapRom = build_cmap();

endpackage

[rtl/wlpc_div_stage.sv]
module wlpc_div_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  wlpc_pkg::div_t      data_i,
  input  wlpc_pkg::pix_t      divisor_i,
  output logic                valid_o,
  output wlpc_pkg::div_t      data_o
);
  import wlpc_pkg::*;

  logic            valid_q;
  div_t            data_d;
  div_t            data_q;
  logic [PixW:0]   rem2;
  logic [PixW:0]   diff;

  // One restoring step: a remainder below the divisor stays below it.
  assign rem2 = {data_i.rem, 1'b0};
  assign diff = rem2 - {1'b0, divisor_i};

  always_comb begin
    data_d = data_i;
    if (rem2 >= {1'b0, divisor_i}) begin
      data_d.rem = diff[PixW-1:0];
      data_d.quo = {data_i.quo[PixW-2:0], 1'b1};
    end else begin
      data_d.rem = rem2[PixW-1:0];
      data_d.quo = {data_i.quo[PixW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

[rtl/window_level_pseudocolor_map.sv]
// Window/level ramp with optional inversion and false-colour lookup.
//
// A request is a gray pixel on pixel_in_i, taken at a rising edge with start
// high. busy is always low, so a new request may be issued in every cycle.
// For each request, result_valid_o is high for exactly one cycle with
// level_out_o and the red, green and blue channels. Throughput is one pixel
// per clock; the pipeline holds the window divider, which resolves one quotient
// bit per pipeline stage over eight stages, plus an entry stage, a level
// stage and the colour table stage. The receiver cannot stall, so results
// are never held back. The configuration port writes black level, white
// level, invert and colour mode at indices 0 to 3; writes are to be made
// only while no request is in flight, which the block does not enforce.
// Reset empties the pipeline and sets black 0, white 255, no inversion and
// gray mode. The colour table is constant and needs no initialisation.
module window_level_pseudocolor_map (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  wlpc_pkg::pix_t   pixel_in_i,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  wlpc_pkg::pix_t   cfg_data_i,
  output logic             result_valid_o,
  output wlpc_pkg::pix_t   level_out_o,
  output wlpc_pkg::pix_t   red_out_o,
  output wlpc_pkg::pix_t   green_out_o,
  output wlpc_pkg::pix_t   blue_out_o
);
  import wlpc_pkg::*;

  pix_t  black_q;
  pix_t  white_q;
  logic  invert_q;
  logic  color_q;

  pix_t  blk_eff;
  pix_t  divisor;

  logic  entry_vld_q;
  div_t  entry_d;
  div_t  entry_q;

  logic  div_vld  [NumDivSteps+1];
  div_t  div_data [NumDivSteps+1];

  logic  lvl_vld_q;
  pix_t  lvl_d;
  pix_t  lvl_q;

  logic  out_vld_q;
  pix_t  out_lvl_q;
  rgb_t  out_rgb_d;
  rgb_t  out_rgb_q;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      black_q  <= '0;
      white_q  <= '1;
      invert_q <= 1'b0;
      color_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegBlack:  black_q  <= cfg_data_i;
        RegWhite:  white_q  <= cfg_data_i;
        RegInvert: invert_q <= cfg_data_i[0];
        RegColor:  color_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign blk_eff = (black_q > white_q) ? white_q : black_q;
  assign divisor = white_q - blk_eff;

  always_comb begin
    entry_d.below = pixel_in_i < blk_eff;
    entry_d.above = pixel_in_i >= white_q;
    entry_d.rem   = pixel_in_i - blk_eff;
    entry_d.quo   = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_vld_q <= 1'b0;
    end else begin
      entry_vld_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign div_vld[0]  = entry_vld_q;
  assign div_data[0] = entry_q;

  for (genvar k = 0; k < NumDivSteps; k++) begin : g_div
    wlpc_div_stage u_step (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .valid_i   (div_vld[k]),
      .data_i    (div_data[k]),
      .divisor_i (divisor),
      .valid_o   (div_vld[k+1]),
      .data_o    (div_data[k+1])
    );
  end

  always_comb begin
    if (div_data[NumDivSteps].below) begin
      lvl_d = '0;
    end else if (div_data[NumDivSteps].above) begin
      lvl_d = '1;
    end else begin
      lvl_d = div_data[NumDivSteps].quo;
    end
    if (invert_q) begin
      lvl_d = ~lvl_d;
    end
  end

  assign out_rgb_d = color_q ? CmapRom[lvl_q] : {lvl_q, lvl_q, lvl_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvl_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      lvl_vld_q <= div_vld[NumDivSteps];
      out_vld_q <= lvl_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    lvl_q     <= lvl_d;
    out_lvl_q <= lvl_q;
    out_rgb_q <= out_rgb_d;
  end

  assign result_valid_o = out_vld_q;
  assign level_out_o    = out_lvl_q;
  assign red_out_o      = out_rgb_q[3*PixW-1:2*PixW];
  assign green_out_o    = out_rgb_q[2*PixW-1:PixW];
  assign blue_out_o     = out_rgb_q[PixW-1:0];

endmodule

[tb/sv/window_level_pseudocolor_map_tb.sv]
`timescale 1ns / 100ps

module window_level_pseudocolor_map_tb;
  import wlpc_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int PrintLimit = 40;
  localparam int RandomPhases = 15;
  localparam int PhaseItems = 100;

  localparam int KnotPos [15] = '{
    -616, -569, -528, -469, -400, -383, -361, -305, -259, -240, -229, -162, -83, -20, 0
  };
  localparam int KnotRgb [15][3] = '{
    '{255,   0, 255}, '{179,   0, 255}, '{120,  40, 255}, '{ 60,  96, 255},
    '{  0, 175, 177}, '{  0, 191, 143}, '{  0, 207,  78}, '{ 90, 255,  60},
    '{191, 255,   0}, '{239, 255,   0}, '{255, 255,   0}, '{255, 175,   0},
    '{255, 105,   0}, '{255,  45,  55}, '{255,   0,  90}
  };

  typedef struct packed {
    pix_t level;
    pix_t red;
    pix_t green;
    pix_t blue;
  } shade_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  pix_t pixel_in = '0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_idx = RegBlack;
  pix_t cfg_data = '0;
  logic result_valid;
  pix_t level_out;
  pix_t red_out;
  pix_t green_out;
  pix_t blue_out;

  window_level_pseudocolor_map dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .pixel_in_i     (pixel_in),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .result_valid_o (result_valid),
    .level_out_o    (level_out),
    .red_out_o      (red_out),
    .green_out_o    (green_out),
    .blue_out_o     (blue_out)
  );

  rgb_t color_table [256];
  pix_t black_reg;
  pix_t white_reg;
  logic invert_reg;
  logic color_reg;
  pix_t gray_queue [$];
  shade_t due_shades [$];
  int mismatches = 0;
  int cycles = 0;
  int gap_left = 0;
  bit idling_on = 1'b1;

  always #5 clk_i = ~clk_i;

  function automatic void fill_color_table();
    int seg;
    int t;
    int n;
    int d;
    int num;
    int q;
    seg = 0;
    for (int i = 0; i < 256; i++) begin
      t = 616 * i - 616 * 255;
      if (t > 255 * KnotPos[seg+1]) begin
        seg = seg + 1;
        if (seg > 13) begin
          seg = 13;
        end
      end
      n = t - 255 * KnotPos[seg];
      d = 255 * (KnotPos[seg+1] - KnotPos[seg]);
      for (int c = 0; c < 3; c++) begin
        num = KnotRgb[seg][c] * (d - n) + KnotRgb[seg+1][c] * n;
        q = num / d;
        if (q < 0) begin
          q = 0;
        end
        if (q > 255) begin
          q = 255;
        end
        color_table[i][8*(2-c) +: 8] = q[7:0];
      end
    end
  endfunction

  function automatic shade_t map_pixel(pix_t p);
    shade_t s;
    int b;
    int w;
    int v;
    b = int'(black_reg);
    w = int'(white_reg);
    if (b > w) begin
      b = w;
    end
    if (int'(p) < b) begin
      v = 0;
    end else if (int'(p) >= w) begin
      v = 255;
    end else begin
      v = ((int'(p) - b) * 256) / (w - b);
    end
    if (invert_reg) begin
      v = 255 - v;
    end
    s.level = v[7:0];
    if (color_reg) begin
      s.red = color_table[v[7:0]][23:16];
      s.green = color_table[v[7:0]][15:8];
      s.blue = color_table[v[7:0]][7:0];
    end else begin
      s.red = v[7:0];
      s.green = v[7:0];
      s.blue = v[7:0];
    end
    return s;
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int want);
    if (mismatches < PrintLimit) begin
      $display("[%0t] mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
    end
    mismatches++;
  endtask

  task automatic write_reg(input logic [1:0] idx, input pix_t data);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    case (idx)
      RegBlack: black_reg = data;
      RegWhite: white_reg = data;
      RegInvert: invert_reg = data[0];
      RegColor: color_reg = data[0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    do begin
      @(negedge clk_i);
    end while (gray_queue.size() != 0 || start || due_shades.size() != 0);
  endtask

  task automatic random_phase(input int count);
    logic [1:0] order [4];
    pix_t b;
    pix_t w;
    int pick;
    int off;
    int lo;
    int hi;
    order = '{RegBlack, RegWhite, RegInvert, RegColor};
    pick = $urandom_range(0, 9);
    b = (pick < 2) ? 8'd0 : (pick == 2) ? 8'd255 : pix_t'($urandom_range(0, 255));
    pick = $urandom_range(0, 9);
    w = (pick < 2) ? 8'd255 : (pick == 2) ? 8'd0 : (pick == 3) ? b :
        pix_t'($urandom_range(0, 255));
    if ($urandom_range(0, 3) == 0) begin
      write_reg(order[$urandom_range(0, 3)], pix_t'($urandom_range(0, 255)));
    end
    off = $urandom_range(0, 3);
    for (int k = 0; k < 4; k++) begin
      case (order[(k + off) % 4])
        RegBlack: write_reg(RegBlack, b);
        RegWhite: write_reg(RegWhite, w);
        RegInvert: write_reg(RegInvert, pix_t'($urandom_range(0, 255)));
        default: write_reg(RegColor, pix_t'($urandom_range(0, 255)));
      endcase
    end
    lo = (b < w) ? int'(b) - 3 : int'(w) - 3;
    hi = int'(w) + 3;
    if (lo < 0) begin
      lo = 0;
    end
    if (hi > 255) begin
      hi = 255;
    end
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 1) == 0) begin
        gray_queue.push_back(pix_t'($urandom_range(0, 255)));
      end else begin
        gray_queue.push_back(pix_t'($urandom_range(lo, hi)));
      end
    end
    drain();
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      pixel_in <= '0;
      gap_left = 0;
    end else begin
      if (start && !busy) begin
        due_shades.push_back(map_pixel(pixel_in));
      end
      if (start && busy) begin
        start <= 1'b1;
      end else if (gap_left > 0) begin
        start <= 1'b0;
        pixel_in <= pix_t'($urandom_range(0, 255));
        gap_left--;
      end else if (gray_queue.size() > 0) begin
        start <= 1'b1;
        pixel_in <= gray_queue.pop_front();
        if (idling_on && $urandom_range(0, 5) == 0) begin
          gap_left = $urandom_range(1, 9);
        end
      end else begin
        start <= 1'b0;
        pixel_in <= pix_t'($urandom_range(0, 255));
      end
    end
  end

  always @(posedge clk_i) begin
    shade_t want;
    if (rst_ni && result_valid) begin
      if (due_shades.size() == 0) begin
        flag_mismatch("unexpected result level", int'(level_out), 0);
      end else begin
        want = due_shades.pop_front();
        if (level_out !== want.level) begin
          flag_mismatch("level", int'(level_out), int'(want.level));
        end
        if (red_out !== want.red) begin
          flag_mismatch("red", int'(red_out), int'(want.red));
        end
        if (green_out !== want.green) begin
          flag_mismatch("green", int'(green_out), int'(want.green));
        end
        if (blue_out !== want.blue) begin
          flag_mismatch("blue", int'(blue_out), int'(want.blue));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    fill_color_table();
    black_reg = 8'd0;
    white_reg = 8'd255;
    invert_reg = 1'b0;
    color_reg = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: full window, gray output.
    gray_queue = '{8'd0, 8'd255, 8'd128, 8'd1, 8'd254};
    drain();

    write_reg(RegColor, 8'hFF);
    gray_queue = '{8'd0, 8'd255, 8'd85, 8'd170};
    drain();

    // Black above white: the window collapses onto the white level.
    write_reg(RegBlack, 8'd200);
    write_reg(RegWhite, 8'd100);
    write_reg(RegInvert, 8'h01);
    write_reg(RegColor, 8'hFE);
    gray_queue = '{8'd99, 8'd100, 8'd101, 8'd0};
    drain();

    // Empty window.
    write_reg(RegBlack, 8'd60);
    write_reg(RegWhite, 8'd60);
    write_reg(RegInvert, 8'h00);
    gray_queue = '{8'd59, 8'd60, 8'd61};
    drain();

    write_reg(RegBlack, 8'd10);
    write_reg(RegWhite, 8'd250);
    write_reg(RegInvert, 8'h03);
    write_reg(RegColor, 8'h81);
    gray_queue = '{8'd9, 8'd10, 8'd11, 8'd249, 8'd250};
    drain();

    for (int ph = 0; ph < RandomPhases; ph++) begin
      idling_on = (ph != RandomPhases - 1) && ($urandom_range(0, 3) != 0);
      random_phase(PhaseItems);
    end

    repeat (30) @(posedge clk_i);
    if (mismatches == 0 && due_shades.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
